// ===== rtl/blos_pkg.sv =====
`default_nettype none

package blos_pkg;

	localparam int COORD_BITS = 16;
	localparam int CELL_W     = 11;
	localparam int GRID_W     = 7;
	localparam int PIX_W      = CELL_W + GRID_W;
	localparam int QCNT_W     = 3;
	localparam int FIELD_W    = 6;
	localparam int ATTR_W     = 8;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 4;

	localparam logic [CELL_W-1:0] CELL_W_RESET = 11'd32;
	localparam logic [CELL_W-1:0] CELL_H_RESET = 11'd32;
	localparam logic [GRID_W-1:0] GRID_W_RESET = 7'd64;
	localparam logic [GRID_W-1:0] GRID_H_RESET = 7'd64;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_CELL_WIDTH  = 2'd0,
		REG_CELL_HEIGHT = 2'd1,
		REG_GRID_WIDTH  = 2'd2,
		REG_GRID_HEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                         action;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic [ATTR_W-1:0]            block_mask;
		logic [FIELD_W-1:0]           cell_col;
		logic [FIELD_W-1:0]           cell_row;
		logic [ATTR_W-1:0]            cell_attr;
	} item_t;

	typedef struct packed {
		logic line_clear;
		logic was_query;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/blos_ram.sv =====
`default_nettype none

module blos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bresenham_line_of_sight.sv =====
`default_nettype none

// channel   signals                                   beat taken when
// config    psel penable pwrite paddr pwdata prdata    psel & penable & pwrite (pready = 1)
// item      start busy item                            start & !busy
// result    done result                                done (one cycle, no back-pressure)
//
// After reset a clearing pass writes zero to all MAX_GRID_COLS*MAX_GRID_ROWS cells,
// one per cycle; busy stays high meanwhile, config writes are still taken.
// Write: the cell index drops by the store depth while it is past it (not normally), then is stored.
// Query: a setup step, then per pixel visited a bounds check, 7-step divide for x and for y
// on the shared restoring divider, RAM read, test/step; a pixel outside the plane
// ends the walk at its check. done pulses the cycle after the last step.

module bresenham_line_of_sight #(
	parameter int MAX_GRID_COLS = 64,
	parameter int MAX_GRID_ROWS = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [blos_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [blos_pkg::DATA_W-1:0]    pwdata,
	output logic      [blos_pkg::DATA_W-1:0]    prdata,
	output logic                                pready,
	input  wire logic                           start,
	output logic                                busy,
	input  wire blos_pkg::item_t                item,
	output logic                                done,
	output blos_pkg::result_t                   result
);

	import blos_pkg::*;

	localparam int DEPTH = MAX_GRID_COLS * MAX_GRID_ROWS;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int WW    = AW + 7;
	localparam int CW    = COORD_BITS;
	localparam int DW    = COORD_BITS + 1;
	localparam int XW    = ((COORD_BITS > PIX_W) ? COORD_BITS : PIX_W) + 1;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_WRAP  = 9'b000000100,
		ST_SETUP = 9'b000001000,
		ST_CHECK = 9'b000010000,
		ST_DIVX  = 9'b000100000,
		ST_DIVY  = 9'b001000000,
		ST_READ  = 9'b010000000,
		ST_TEST  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [CELL_W-1:0] cell_w_q, cell_h_q;
	logic [GRID_W-1:0] grid_w_q, grid_h_q;
	logic [AW-1:0]     clr_q;
	logic              done_q;
	result_t           result_q;

	// per-item payload
	logic [CW-1:0]     sx_q, sy_q, ex_q, ey_q;
	logic [ATTR_W-1:0] mask_q, attr_q;
	logic [WW-1:0]     w_q;
	logic [PIX_W-1:0]  pw_q, ph_q;
	logic [CELL_W-1:0] cw_eff_q, ch_eff_q;

	// walk state
	logic [CW-1:0]     px_q, py_q;
	logic [CW-1:0]     major_q, minor_q, acc_q, remain_q;
	logic              x_major_q, neg_x_q, neg_y_q;

	// shared divider
	logic [PIX_W-1:0]  rem_q;
	logic [GRID_W-1:0] quo_q, col_q, row_q;
	logic [QCNT_W-1:0] cnt_q;

	logic [ATTR_W-1:0] rdata;

	// config
	logic     cfg_we;
	reg_idx_t cfg_idx;
	assign cfg_we  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_comb begin
		unique case (cfg_idx)
			REG_CELL_WIDTH:  prdata = DATA_W'(cell_w_q);
			REG_CELL_HEIGHT: prdata = DATA_W'(cell_h_q);
			REG_GRID_WIDTH:  prdata = DATA_W'(grid_w_q);
			REG_GRID_HEIGHT: prdata = DATA_W'(grid_h_q);
			default:         prdata = '0;
		endcase
	end

	// effective geometry
	logic [CELL_W-1:0] cw_eff, ch_eff;
	logic [GRID_W-1:0] gw_eff, gh_eff;
	always_comb begin
		cw_eff = (cell_w_q == '0) ? CELL_W'(1) : cell_w_q;
		ch_eff = (cell_h_q == '0) ? CELL_W'(1) : cell_h_q;
		gw_eff = (CELL_W'(grid_w_q) > CELL_W'(MAX_GRID_COLS)) ? GRID_W'(MAX_GRID_COLS)
			: grid_w_q;
		gh_eff = (CELL_W'(grid_h_q) > CELL_W'(MAX_GRID_ROWS)) ? GRID_W'(MAX_GRID_ROWS)
			: grid_h_q;
	end

	// write index wrap
	logic wrap_ge;
	assign wrap_ge = ({1'b0, w_q} >= (WW + 1)'(DEPTH));

	// line setup
	logic [DW-1:0] dx, dy, adx_w, ady_w;
	logic [CW-1:0] adx, ady;
	logic          xmaj;
	always_comb begin
		dx    = {ex_q[CW-1], ex_q} - {sx_q[CW-1], sx_q};
		dy    = {ey_q[CW-1], ey_q} - {sy_q[CW-1], sy_q};
		adx_w = dx[DW-1] ? (~dx + DW'(1)) : dx;
		ady_w = dy[DW-1] ? (~dy + DW'(1)) : dy;
		adx   = adx_w[CW-1:0];
		ady   = ady_w[CW-1:0];
		xmaj  = (adx >= ady);
	end

	// bounds check
	logic [XW-1:0] x_ext, y_ext;
	logic          in_plane;
	always_comb begin
		x_ext    = {{(XW - CW){px_q[CW-1]}}, px_q};
		y_ext    = {{(XW - CW){py_q[CW-1]}}, py_q};
		in_plane = !px_q[CW-1] && !py_q[CW-1]
			&& (x_ext < XW'(pw_q)) && (y_ext < XW'(ph_q));
	end

	// restoring divider, one quotient bit per cycle
	logic [CELL_W-1:0] div_sel;
	logic [PIX_W-1:0]  shifted, rem_nx;
	logic [GRID_W-1:0] quo_nx;
	logic              div_ge;
	always_comb begin
		div_sel = (state_q == ST_DIVY) ? ch_eff_q : cw_eff_q;
		shifted = PIX_W'(div_sel) << cnt_q;
		div_ge  = (rem_q >= shifted);
		rem_nx  = div_ge ? (rem_q - shifted) : rem_q;
		quo_nx  = quo_q | (div_ge ? (GRID_W'(1) << cnt_q) : '0);
	end

	// Bresenham step
	logic [CW:0]   acc_sum, acc_red;
	logic          minor_step, move_x, move_y, blocked;
	logic [CW-1:0] px_nx, py_nx;
	always_comb begin
		acc_sum    = {1'b0, acc_q} + {1'b0, minor_q};
		minor_step = (acc_sum >= {1'b0, major_q});
		acc_red    = acc_sum - {1'b0, major_q};
		move_x     = x_major_q | minor_step;
		move_y     = !x_major_q | minor_step;
		px_nx      = !move_x ? px_q : (neg_x_q ? px_q - CW'(1) : px_q + CW'(1));
		py_nx      = !move_y ? py_q : (neg_y_q ? py_q - CW'(1) : py_q + CW'(1));
		blocked    = ((rdata & mask_q) != '0);
	end

	// last cycle of an item: write stored, pixel off the plane, or walk finished
	logic item_end;
	assign item_end = ((state_q == ST_WRAP) && !wrap_ge)
		|| ((state_q == ST_CHECK) && !in_plane)
		|| ((state_q == ST_TEST) && (blocked || remain_q == '0));

	logic [AW-1:0] rd_addr;
	assign rd_addr = AW'(row_q) * AW'(MAX_GRID_COLS) + AW'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			cell_w_q <= CELL_W_RESET;
			cell_h_q <= CELL_H_RESET;
			grid_w_q <= GRID_W_RESET;
			grid_h_q <= GRID_H_RESET;
		end else begin
			done_q <= item_end;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_CELL_WIDTH:  cell_w_q <= pwdata[CELL_W-1:0];
					REG_CELL_HEIGHT: cell_h_q <= pwdata[CELL_W-1:0];
					REG_GRID_WIDTH:  grid_w_q <= pwdata[GRID_W-1:0];
					REG_GRID_HEIGHT: grid_h_q <= pwdata[GRID_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= (item.action == ACT_QUERY) ? ST_SETUP : ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (!wrap_ge) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SETUP: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (!in_plane) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (cnt_q == '0) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_TEST;
				ST_TEST: begin
					if (blocked || remain_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					sx_q     <= item.start_x;
					sy_q     <= item.start_y;
					ex_q     <= item.end_x;
					ey_q     <= item.end_y;
					mask_q   <= item.block_mask;
					attr_q   <= item.cell_attr;
					w_q      <= WW'(item.cell_row) * WW'(MAX_GRID_COLS) + WW'(item.cell_col);
					pw_q     <= PIX_W'(gw_eff) * PIX_W'(cw_eff);
					ph_q     <= PIX_W'(gh_eff) * PIX_W'(ch_eff);
					cw_eff_q <= cw_eff;
					ch_eff_q <= ch_eff;
				end
			end
			ST_WRAP: begin
				if (wrap_ge) begin
					w_q <= w_q - WW'(DEPTH);
				end else begin
					result_q <= '{line_clear: 1'b0, was_query: 1'b0};
				end
			end
			ST_SETUP: begin
				px_q      <= sx_q;
				py_q      <= sy_q;
				x_major_q <= xmaj;
				neg_x_q   <= dx[DW-1];
				neg_y_q   <= dy[DW-1];
				major_q   <= xmaj ? adx : ady;
				minor_q   <= xmaj ? ady : adx;
				remain_q  <= xmaj ? adx : ady;
				acc_q     <= '0;
			end
			ST_CHECK: begin
				if (!in_plane) begin
					result_q <= '{line_clear: 1'b0, was_query: 1'b1};
				end else begin
					rem_q <= x_ext[PIX_W-1:0];
					quo_q <= '0;
					cnt_q <= QCNT_W'(GRID_W - 1);
				end
			end
			ST_DIVX: begin
				if (cnt_q == '0) begin
					col_q <= quo_nx;
					rem_q <= y_ext[PIX_W-1:0];
					quo_q <= '0;
					cnt_q <= QCNT_W'(GRID_W - 1);
				end else begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - QCNT_W'(1);
				end
			end
			ST_DIVY: begin
				if (cnt_q == '0) begin
					row_q <= quo_nx;
				end else begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - QCNT_W'(1);
				end
			end
			ST_TEST: begin
				if (blocked) begin
					result_q <= '{line_clear: 1'b0, was_query: 1'b1};
				end else if (remain_q == '0) begin
					result_q <= '{line_clear: 1'b1, was_query: 1'b1};
				end else begin
					px_q     <= px_nx;
					py_q     <= py_nx;
					acc_q    <= minor_step ? acc_red[CW-1:0] : acc_sum[CW-1:0];
					remain_q <= remain_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ATTR_W-1:0] ram_wdata;
	always_comb begin
		ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_WRAP) && !wrap_ge);
		ram_waddr = (state_q == ST_CLEAR) ? clr_q : w_q[AW-1:0];
		ram_wdata = (state_q == ST_CLEAR) ? '0 : attr_q;
	end

	blos_ram #(
		.WIDTH (ATTR_W),
		.DEPTH (DEPTH)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (state_q == ST_READ),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== tb/tb_bresenham_line_of_sight.sv =====
`timescale 1ns / 1ps

module tb_bresenham_line_of_sight;
	import blos_pkg::*;

	localparam int     MAP_COLS        = 64;
	localparam int     MAP_ROWS        = 64;
	localparam int     ITEMS_PER_PHASE = 100;
	localparam int     PHASES          = 16;
	localparam int     MAX_WALK        = 400;
	localparam int     WATCHDOG_LIMIT  = 200000;
	localparam int     TAIL_CYCLES     = 40;
	localparam int     PRINT_CAP       = 100;
	localparam longint COORD_MAX       = (longint'(1) <<< (COORD_BITS - 1)) - 1;

	typedef enum logic [1:0] {OP_ITEM, OP_CONFIG, OP_DRAIN} op_kind_t;
	typedef enum logic [2:0] {
		DRV_BOOT, DRV_GAP, DRV_ITEM, DRV_QUIESCE, DRV_SETUP, DRV_ACCESS, DRV_DONE
	} drv_state_t;

	// register values indexed by reg_idx_t
	typedef int unsigned geom_t [4];

	typedef struct {
		op_kind_t          kind;
		item_t             payload;
		reg_idx_t          target;
		logic [DATA_W-1:0] value;
		int                gap;
	} op_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b1;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start   = 1'b0;
	logic              busy;
	item_t             item    = '0;
	logic              done;
	result_t           result;

	bresenham_line_of_sight #(
		.MAX_GRID_COLS(MAP_COLS),
		.MAX_GRID_ROWS(MAP_ROWS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	op_t             plan [$];
	result_t         owed_verdicts [$];
	logic [ATTR_W-1:0] cell_attr_map [MAP_COLS*MAP_ROWS];
	geom_t           live_geom = '{CELL_W_RESET, CELL_H_RESET, GRID_W_RESET, GRID_H_RESET};
	int              mismatches = 0;
	int              results_seen = 0;

	initial begin
		foreach (cell_attr_map[i])
			cell_attr_map[i] = '0;
	end

	function automatic void plan_op(op_kind_t kind, item_t payload, reg_idx_t target,
			logic [DATA_W-1:0] value, int gap);
		op_t op;
		op.kind = kind;
		op.payload = payload;
		op.target = target;
		op.value = value;
		op.gap = gap;
		plan = {plan, op};
	endfunction

	function automatic bit pixel_open(longint x, longint y, logic [ATTR_W-1:0] mask,
			geom_t g, bit use_cells);
		longint cw, ch, pw, ph;
		cw = (g[REG_CELL_WIDTH] == 0) ? 1 : g[REG_CELL_WIDTH];
		ch = (g[REG_CELL_HEIGHT] == 0) ? 1 : g[REG_CELL_HEIGHT];
		pw = cw * ((g[REG_GRID_WIDTH] > MAP_COLS) ? MAP_COLS : g[REG_GRID_WIDTH]);
		ph = ch * ((g[REG_GRID_HEIGHT] > MAP_ROWS) ? MAP_ROWS : g[REG_GRID_HEIGHT]);
		if (x < 0 || y < 0 || x >= pw || y >= ph)
			return 1'b0;
		if (!use_cells)
			return 1'b1;
		return (cell_attr_map[(y / ch) * MAP_COLS + (x / cw)] & mask) == '0;
	endfunction

	// Walks as the block does, axis-aligned lines from low end; visited counts pixels
	// looked at. With use_cells low only the plane bounds stop it: the worst-case walk.
	function automatic bit sight_clear(item_t it, geom_t g, bit use_cells, output int visited);
		longint sx, sy, ex, ey, dx, dy, lo, hi, p;
		longint major, minor, acc, a, b, sa, sb, t;
		bit x_major;
		sx = $signed(it.start_x);
		sy = $signed(it.start_y);
		ex = $signed(it.end_x);
		ey = $signed(it.end_y);
		dx = ex - sx;
		dy = ey - sy;
		visited = 0;
		if (dx == 0 || dy == 0) begin
			// axis-aligned: low end to high end, other coordinate taken from the end point
			lo = (dx == 0) ? ((dy < 0) ? ey : sy) : ((dx < 0) ? ex : sx);
			hi = (dx == 0) ? ((dy < 0) ? sy : ey) : ((dx < 0) ? sx : ex);
			for (p = lo; p <= hi; p++) begin
				visited++;
				if (!((dx == 0) ? pixel_open(ex, p, it.block_mask, g, use_cells)
						: pixel_open(p, ey, it.block_mask, g, use_cells)))
					return 1'b0;
			end
			return 1'b1;
		end
		sa = (dx < 0) ? -1 : 1;
		sb = (dy < 0) ? -1 : 1;
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		x_major = (dx >= dy);
		if (x_major) begin
			major = dx;
			minor = dy;
			a = sx;
			b = sy;
		end else begin
			t = sa;
			sa = sb;
			sb = t;
			major = dy;
			minor = dx;
			a = sy;
			b = sx;
		end
		visited = 1;
		if (!pixel_open(sx, sy, it.block_mask, g, use_cells))
			return 1'b0;
		acc = 0;
		for (p = major; p != 0; p--) begin
			acc += minor;
			a += sa;
			// minor axis truncates: steps only once the error reaches the major delta
			if (acc >= major) begin
				b += sb;
				acc -= major;
			end
			visited++;
			if (!(x_major ? pixel_open(a, b, it.block_mask, g, use_cells)
					: pixel_open(b, a, it.block_mask, g, use_cells)))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic item_t noise_item();
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		return bits[$bits(item_t)-1:0];
	endfunction

	function automatic logic [ATTR_W-1:0] sparse_byte();
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return '0;
		4, 5, 6: return 8'h01 << $urandom_range(0, 7);
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < -COORD_MAX - 1)
			return -COORD_MAX - 1;
		return v;
	endfunction

	// unused fields of the other action stay random
	function automatic item_t line_query(longint sx, longint sy, longint ex, longint ey,
			logic [ATTR_W-1:0] mask);
		item_t it;
		it = noise_item();
		it.action = ACT_QUERY;
		it.start_x = sx[COORD_BITS-1:0];
		it.start_y = sy[COORD_BITS-1:0];
		it.end_x = ex[COORD_BITS-1:0];
		it.end_y = ey[COORD_BITS-1:0];
		it.block_mask = mask;
		return it;
	endfunction

	function automatic item_t cell_write(int col, int row, logic [ATTR_W-1:0] attr);
		item_t it;
		it = noise_item();
		it.action = ACT_WRITE;
		it.cell_col = col[FIELD_W-1:0];
		it.cell_row = row[FIELD_W-1:0];
		it.cell_attr = attr;
		return it;
	endfunction

	function automatic longint random_coord();
		return longint'($urandom_range(0, 2 * COORD_MAX + 1)) - COORD_MAX - 1;
	endfunction

	function automatic item_t random_item(geom_t g);
		item_t it;
		longint span_x, span_y, sx, sy, dx, dy, reach;
		int gw, gh, pick, walk;
		gw = (g[REG_GRID_WIDTH] > MAP_COLS) ? MAP_COLS : int'(g[REG_GRID_WIDTH]);
		gh = (g[REG_GRID_HEIGHT] > MAP_ROWS) ? MAP_ROWS : int'(g[REG_GRID_HEIGHT]);
		span_x = longint'((g[REG_CELL_WIDTH] == 0) ? 1 : g[REG_CELL_WIDTH]) * gw;
		span_y = longint'((g[REG_CELL_HEIGHT] == 0) ? 1 : g[REG_CELL_HEIGHT]) * gh;
		if (span_x > COORD_MAX - 8)
			span_x = COORD_MAX - 8;
		if (span_y > COORD_MAX - 8)
			span_y = COORD_MAX - 8;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			return cell_write(
				(gw != 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, gw - 1)
					: $urandom_range(0, MAP_COLS - 1),
				(gh != 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, gh - 1)
					: $urandom_range(0, MAP_ROWS - 1),
				sparse_byte());
		do begin
			if (pick < 85) begin
				sx = longint'($urandom_range(0, span_x + 5)) - 3;
				sy = longint'($urandom_range(0, span_y + 5)) - 3;
				reach = ($urandom_range(0, 19) == 0) ? 120 : 20;
				dx = longint'($urandom_range(0, 2 * reach)) - reach;
				dy = longint'($urandom_range(0, 2 * reach)) - reach;
				case ($urandom_range(0, 9))
				0: begin
					dx = 0;
					dy = 0;
				end
				1, 2: dx = 0;
				3, 4: dy = 0;
				default: ;
				endcase
				it = line_query(sx, sy, clamp_coord(sx + dx), clamp_coord(sy + dy),
					sparse_byte());
			end else begin
				it = line_query(random_coord(), random_coord(), random_coord(),
					random_coord(), 8'($urandom));
			end
			void'(sight_clear(it, g, 1'b0, walk));
		end while (walk > MAX_WALK);
		return it;
	endfunction

	initial begin : build_plan
		item_t opening [$];
		geom_t listed [10] = '{
			'{1, 1, 64, 64}, '{4, 3, 16, 20}, '{0, 0, 127, 100}, '{2047, 2047, 1, 1},
			'{1024, 1024, 64, 64}, '{7, 5, 0, 33}, '{3, 8, 64, 1}, '{16, 16, 10, 10},
			'{2, 1, 65, 2}, '{5, 9, 40, 0}
		};
		geom_t plan_geom;
		bit burst;

		// default geometry: 32 px cells, 2048 x 2048 px plane
		opening = {opening, cell_write(0, 0, 8'h01)};
		opening = {opening, cell_write(63, 63, 8'h80)};
		opening = {opening, cell_write(20, 1, 8'hff)};
		opening = {opening, line_query(0, 0, 0, 0, 8'h01)};
		opening = {opening, line_query(0, 0, 0, 0, 8'hfe)};
		opening = {opening, line_query(2047, 2047, 2047, 2047, 8'h80)};
		opening = {opening, line_query(2047, 2047, 2047, 2047, 8'h7f)};
		opening = {opening, line_query(2048, 5, 2048, 5, 8'h00)};
		opening = {opening, line_query(-1, 5, -1, 5, 8'h00)};
		opening = {opening, line_query(40, 100, 40, 10, 8'h01)};
		opening = {opening, line_query(700, 40, 600, 40, 8'h10)};
		opening = {opening, line_query(700, 100, 600, 100, 8'hff)};
		opening = {opening, line_query(-32768, -32768, 32767, 32767, 8'h00)};
		opening = {opening, line_query(32767, -32768, -32768, 32767, 8'hff)};
		opening = {opening, line_query(5, -32768, 5, 32767, 8'h00)};
		opening = {opening, line_query(-32768, 7, 32767, 7, 8'h00)};
		opening = {opening, line_query(10, 10, 13, 60, 8'h00)};
		opening = {opening, line_query(100, 50, 20, 45, 8'h02)};
		opening = {opening, line_query(2040, 10, 2060, 15, 8'h00)};
		opening = {opening, line_query(600, 80, 700, 20, 8'h04)};
		opening = {opening, line_query(0, 0, 2047, 2047, 8'h00)};
		opening = {opening, cell_write(0, 0, 8'h00)};
		foreach (opening[i])
			plan_op(OP_ITEM, opening[i], REG_CELL_WIDTH, 0, $urandom_range(0, 19));
		plan_op(OP_DRAIN, '0, REG_CELL_WIDTH, 0, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 10) begin
				plan_geom = listed[ph];
			end else begin
				plan_geom[REG_CELL_WIDTH] = $urandom_range(1, 12);
				plan_geom[REG_CELL_HEIGHT] = $urandom_range(1, 12);
				plan_geom[REG_GRID_WIDTH] = $urandom_range(1, 64);
				plan_geom[REG_GRID_HEIGHT] = $urandom_range(1, 64);
			end
			for (int r = 0; r < 4; r++)
				plan_op(OP_CONFIG, '0, reg_idx_t'(r), plan_geom[r], 0);
			burst = (ph % 4 == 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 79) == 0)
					plan_op(OP_DRAIN, '0, REG_CELL_WIDTH, 0, 0);
				plan_op(OP_ITEM, random_item(plan_geom), REG_CELL_WIDTH, 0,
					burst ? 0 : $urandom_range(0, 19));
			end
		end
	end

	op_t        cur_op;
	int         gap_left;
	int         walk_len;
	result_t    verdict;
	drv_state_t drv_state = DRV_BOOT;

	task automatic take_next();
		if (plan.size() == 0) begin
			start <= 1'b0;
			drv_state <= DRV_DONE;
		end else begin
			cur_op = plan.pop_front();
			gap_left = cur_op.gap;
			if (cur_op.kind == OP_ITEM && cur_op.gap == 0) begin
				// back-to-back beat: start stays high
				start <= 1'b1;
				item <= cur_op.payload;
				drv_state <= DRV_ITEM;
			end else begin
				start <= 1'b0;
				drv_state <= (cur_op.kind == OP_ITEM) ? DRV_GAP : DRV_QUIESCE;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			case (drv_state)
			DRV_BOOT: take_next();
			DRV_GAP: begin
				if (gap_left <= 1) begin
					start <= 1'b1;
					item <= cur_op.payload;
					drv_state <= DRV_ITEM;
				end else begin
					gap_left--;
				end
			end
			DRV_ITEM: begin
				if (start && !busy) begin
					verdict.was_query = (item.action == ACT_QUERY);
					verdict.line_clear = 1'b0;
					if (item.action == ACT_QUERY)
						verdict.line_clear = sight_clear(item, live_geom, 1'b1, walk_len);
					else
						cell_attr_map[item.cell_row * MAP_COLS + item.cell_col] = item.cell_attr;
					owed_verdicts = {owed_verdicts, verdict};
					take_next();
				end
			end
			DRV_QUIESCE: begin
				// done is checked so that a result retired on this edge is never half-seen
				if (owed_verdicts.size() == 0 && !done && !busy) begin
					if (cur_op.kind == OP_DRAIN) begin
						take_next();
					end else begin
						psel <= 1'b1;
						penable <= 1'b0;
						paddr <= {cur_op.target, 2'b00};
						pwdata <= cur_op.value;
						drv_state <= DRV_SETUP;
					end
				end
			end
			DRV_SETUP: begin
				penable <= 1'b1;
				drv_state <= DRV_ACCESS;
			end
			DRV_ACCESS: begin
				if (pready) begin
					live_geom[cur_op.target] =
						(cur_op.target == REG_CELL_WIDTH || cur_op.target == REG_CELL_HEIGHT)
						? cur_op.value[CELL_W-1:0] : cur_op.value[GRID_W-1:0];
					psel <= 1'b0;
					penable <= 1'b0;
					take_next();
				end
			end
			default: ;
			endcase
		end
	end

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	result_t owed;

	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (owed_verdicts.size() == 0) begin
				report_mismatch($sformatf("result beat %0d (%b) with no item outstanding",
					results_seen, result));
			end else begin
				owed = owed_verdicts.pop_front();
				if (result.line_clear !== owed.line_clear)
					report_mismatch($sformatf("result beat %0d line_clear %b, want %b",
						results_seen, result.line_clear, owed.line_clear));
				if (result.was_query !== owed.was_query)
					report_mismatch($sformatf("result beat %0d was_query %b, want %b",
						results_seen, result.was_query, owed.was_query));
			end
		end
	end

	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_bresenham_line_of_sight: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : finish_run
		wait (drv_state == DRV_DONE);
		@(negedge clk);
		while (owed_verdicts.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb_bresenham_line_of_sight: PASS");
		else
			$display("tb_bresenham_line_of_sight: FAIL");
		$finish;
	end

endmodule
